/* rtl/core/wavhc_pkg.sv */
// wav header checker package: phase codes, tags, status codes, shared structs
`timescale 1ns / 1ps

package wavhc_pkg;

	localparam int unsigned OUT_TDATA_W = 120;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_FACT = 32'h7463_6166;
	localparam logic [31:0] TAG_LIST = 32'h5453_494C;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [31:0] RATE_RESET     = 32'd44100;
	localparam logic [15:0] BITS_RESET     = 16'd16;
	localparam logic [15:0] CHANNELS_RESET = 16'd1;
	localparam logic [15:0] FMT_PCM        = 16'd1;

	typedef enum logic [1:0] {
		CFG_RATE     = 2'd0,
		CFG_BITS     = 2'd1,
		CFG_CHANNELS = 2'd2
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_OK         = 4'd0,
		ST_NO_RIFF    = 4'd1,
		ST_NO_WAVE    = 4'd2,
		ST_NO_FMT     = 4'd3,
		ST_COMPRESSED = 4'd4,
		ST_CHANNELS   = 4'd5,
		ST_RATE       = 4'd6,
		ST_BITS       = 4'd7,
		ST_NO_DATA    = 4'd8
	} status_t;

	typedef enum logic [15:0] {
		PH_RIFF        = 16'h0001,
		PH_RIFF_SIZE   = 16'h0002,
		PH_WAVE        = 16'h0004,
		PH_FMT         = 16'h0008,
		PH_FMT_SIZE    = 16'h0010,
		PH_AUDIO_FMT   = 16'h0020,
		PH_CHANNELS    = 16'h0040,
		PH_RATE        = 16'h0080,
		PH_BYTE_RATE   = 16'h0100,
		PH_BLOCK_ALIGN = 16'h0200,
		PH_BITS        = 16'h0400,
		PH_CHUNK_ID    = 16'h0800,
		PH_SKIP_SIZE   = 16'h1000,
		PH_SKIPPING    = 16'h2000,
		PH_DATA_ID     = 16'h4000,
		PH_DATA_SIZE   = 16'h8000
	} phase_t;

	typedef struct packed {
		logic [31:0] rate;
		logic [15:0] bits;
		logic [15:0] channels;
	} cfg_t;

	typedef struct packed {
		logic [15:0] block_align_out;
		logic [31:0] byte_rate_out;
		logic [30:0] sample_count;
		logic [31:0] data_offset;
		status_t     status;
	} result_t;

	// two-byte fields finish on the second byte
	function automatic logic is_two_byte(input phase_t ph);
		is_two_byte = (ph == PH_AUDIO_FMT) || (ph == PH_CHANNELS) ||
			(ph == PH_BLOCK_ALIGN) || (ph == PH_BITS);
	endfunction

endpackage

/* rtl/core/wavhc_cfg_regs.sv */
// configuration registers for expected rate, bits per sample and channel count
`timescale 1ns / 1ps

module wavhc_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output wavhc_pkg::cfg_t    cfg
);
	import wavhc_pkg::*;

	logic [31:0] rate_q;
	logic [15:0] bits_q;
	logic [15:0] channels_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q     <= RATE_RESET;
			bits_q     <= BITS_RESET;
			channels_q <= CHANNELS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_RATE:     rate_q     <= cfg_data;
				CFG_BITS:     bits_q     <= cfg_data[15:0];
				CFG_CHANNELS: channels_q <= cfg_data[15:0];
				default:      ;
			endcase
		end
	end

	assign cfg.rate     = rate_q;
	assign cfg.bits     = bits_q;
	assign cfg.channels = channels_q;

endmodule

/* rtl/core/wavhc_parser.sv */
// header field state machine: one byte per step, result on completion or failure
`timescale 1ns / 1ps

module wavhc_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         data_byte,
	input  logic               restart,
	input  wavhc_pkg::cfg_t    cfg,
	output logic               emit,
	output wavhc_pkg::result_t result
);
	import wavhc_pkg::*;

	phase_t      phase_q, ph_c, ph_n;
	logic [1:0]  idx_q, idx_c, idx_n, idx_inc;
	logic [31:0] shift_q, shift_c, shift_n;
	logic [31:0] pos_q, pos_c, pos_n;
	logic [31:0] skip_q, skip_c, skip_n;
	logic [31:0] brate_q, brate_c, brate_n;
	logic [15:0] balign_q, balign_c, balign_n;
	logic        fin_q, fin_c, fin_n;
	logic [31:0] v;
	logic        complete;
	status_t     stat;
	logic [31:0] offset;
	logic [30:0] count;

	// restart clears the parser before the byte is taken
	always_comb begin
		ph_c     = restart ? PH_RIFF : phase_q;
		idx_c    = restart ? 2'd0    : idx_q;
		shift_c  = restart ? 32'd0   : shift_q;
		pos_c    = restart ? 32'd0   : pos_q;
		skip_c   = restart ? 32'd0   : skip_q;
		brate_c  = restart ? 32'd0   : brate_q;
		balign_c = restart ? 16'd0   : balign_q;
		fin_c    = restart ? 1'b0    : fin_q;
	end

	always_comb begin
		ph_n     = ph_c;
		idx_n    = idx_c;
		shift_n  = shift_c;
		pos_n    = pos_c;
		skip_n   = skip_c;
		brate_n  = brate_c;
		balign_n = balign_c;
		fin_n    = fin_c;
		emit     = 1'b0;
		stat     = ST_OK;
		offset   = 32'd0;
		count    = 31'd0;
		idx_inc  = idx_c + 2'd1;
		v        = shift_c | ({24'd0, data_byte} << {idx_c, 3'b000});
		complete = (idx_inc == 2'd0) || (is_two_byte(ph_c) && idx_inc == 2'd2);
		if (!fin_c) begin
			pos_n = (pos_c == 32'hFFFF_FFFF) ? pos_c : pos_c + 32'd1;
			if (ph_c == PH_SKIPPING) begin
				skip_n = skip_c - 32'd1;
				if (skip_n == 32'd0) begin
					ph_n = PH_DATA_ID;
				end
			end else if (!complete) begin
				shift_n = v;
				idx_n   = idx_inc;
			end else begin
				shift_n = 32'd0;
				idx_n   = 2'd0;
				case (ph_c)
					PH_RIFF: begin
						if (v != TAG_RIFF) begin
							emit = 1'b1;
							stat = ST_NO_RIFF;
						end else ph_n = PH_RIFF_SIZE;
					end
					PH_RIFF_SIZE: ph_n = PH_WAVE;
					PH_WAVE: begin
						if (v != TAG_WAVE) begin
							emit = 1'b1;
							stat = ST_NO_WAVE;
						end else ph_n = PH_FMT;
					end
					PH_FMT: begin
						if (v != TAG_FMT) begin
							emit = 1'b1;
							stat = ST_NO_FMT;
						end else ph_n = PH_FMT_SIZE;
					end
					PH_FMT_SIZE: ph_n = PH_AUDIO_FMT;
					PH_AUDIO_FMT: begin
						if (v != {16'd0, FMT_PCM}) begin
							emit = 1'b1;
							stat = ST_COMPRESSED;
						end else ph_n = PH_CHANNELS;
					end
					PH_CHANNELS: begin
						if (v != {16'd0, cfg.channels}) begin
							emit = 1'b1;
							stat = ST_CHANNELS;
						end else ph_n = PH_RATE;
					end
					PH_RATE: begin
						if (v != cfg.rate) begin
							emit = 1'b1;
							stat = ST_RATE;
						end else ph_n = PH_BYTE_RATE;
					end
					PH_BYTE_RATE: begin
						brate_n = v;
						ph_n    = PH_BLOCK_ALIGN;
					end
					PH_BLOCK_ALIGN: begin
						balign_n = v[15:0];
						ph_n     = PH_BITS;
					end
					PH_BITS: begin
						if (v != {16'd0, cfg.bits}) begin
							emit = 1'b1;
							stat = ST_BITS;
						end else ph_n = PH_CHUNK_ID;
					end
					PH_CHUNK_ID: begin
						if (v == TAG_FACT || v == TAG_LIST) begin
							ph_n = PH_SKIP_SIZE;
						end else if (v != TAG_DATA) begin
							emit = 1'b1;
							stat = ST_NO_DATA;
						end else ph_n = PH_DATA_SIZE;
					end
					PH_SKIP_SIZE: begin
						skip_n = v;
						ph_n   = (v == 32'd0) ? PH_DATA_ID : PH_SKIPPING;
					end
					PH_DATA_ID: begin
						if (v != TAG_DATA) begin
							emit = 1'b1;
							stat = ST_NO_DATA;
						end else ph_n = PH_DATA_SIZE;
					end
					PH_DATA_SIZE: begin
						emit   = 1'b1;
						stat   = ST_OK;
						offset = pos_n;
						count  = v[31:1];
					end
					default: ;
				endcase
				if (emit) begin
					fin_n = 1'b1;
				end
			end
		end
	end

	assign result.status          = stat;
	assign result.data_offset     = offset;
	assign result.sample_count    = count;
	assign result.byte_rate_out   = brate_c;
	assign result.block_align_out = balign_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_RIFF;
			idx_q    <= 2'd0;
			shift_q  <= 32'd0;
			pos_q    <= 32'd0;
			skip_q   <= 32'd0;
			brate_q  <= 32'd0;
			balign_q <= 16'd0;
			fin_q    <= 1'b0;
		end else if (step) begin
			phase_q  <= ph_n;
			idx_q    <= idx_n;
			shift_q  <= shift_n;
			pos_q    <= pos_n;
			skip_q   <= skip_n;
			brate_q  <= brate_n;
			balign_q <= balign_n;
			fin_q    <= fin_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_result_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit |-> !fin_q || restart)
		else $error("result produced after the parser finished");
	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIPPING |-> skip_q != 32'd0)
		else $error("skipping with nothing left to skip");
	a_finish_latches: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit |=> fin_q)
		else $error("finished flag not set after a result");
`endif

endmodule

/* rtl/core/wav_header_checker_top.sv */
// wav header checker top level: input register, parser and result register
`timescale 1ns / 1ps

// Takes a WAV file one byte per request on the s_ side, tuser set on the first byte of a
// new file, and returns one request on the m_ side when the data chunk size has been read
// or at the first failed header check; later bytes are dropped until the next restart.
// One byte is taken every cycle while no result waits on m_tready; input stalls only then.
// The parser state machine sits between the input register and the result register, so
// a result passes from its last byte through both registers before it appears on m_.
// Expected rate, bits per sample and channel count go in on the cfg port (index 0, 1, 2);
// the user writes them only while no file is in flight; the block does not enforce it.

module wav_header_checker_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // data_byte
	input  logic         s_tuser,  // restart
	output logic         m_tvalid,
	input  logic         m_tready,
	// status, data_offset, sample_count, byte_rate_out, block_align_out, zero pad
	output logic [wavhc_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import wavhc_pkg::*;

	cfg_t        cfg;
	result_t     res;
	result_t     result_q;
	logic        emit;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        restart_s1;
	logic        out_valid_q;
	logic        advance;

	wavhc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1    <= s_tdata;
			restart_s1 <= s_tuser;
		end
	end

	wavhc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.restart   (restart_s1),
		.cfg       (cfg),
		.emit      (emit),
		.result    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, result_q};

`ifndef NO_ASSERTIONS
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> result_q.status <= ST_NO_DATA)
		else $error("status code out of range");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result_q.status != ST_OK |->
		result_q.data_offset == 32'd0 && result_q.sample_count == 31'd0)
		else $error("failure result carries offset or count");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> out_valid_q && !m_tready)
		else $error("input stalled without output back-pressure");
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |=> out_valid_q && $stable(result_q))
		else $error("pending result lost or changed");
`endif

endmodule

/* tb/tb.sv */
// self-checking testbench for the wav header checker: byte streams against a parsing model
`timescale 1ns / 1ps

module tb;
	import wavhc_pkg::*;

	localparam int CLK_HALF = 10;
	localparam int RUN_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int PIPE_CYCLES = 8;
	localparam logic [1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [7:0] b;
		logic       first;
	} wav_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = 2'd0;
	logic [31:0] cfg_data = 32'd0;

	wav_header_checker_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	wav_byte_t byte_q[$];
	logic [7:0] file_q[$];
	result_t due_results[$];

	logic s_took = 1'b0;
	logic steady = 1'b0;
	logic hold_go = 1'b0;
	logic hold_seen = 1'b0;
	int hold_left = 0;
	int cycles = 0;
	int n_errors = 0;
	int n_results = 0;
	int n_pushed = 0;
	int n_settings = 1;

	// header values the generator writes into well-formed files
	logic [31:0] gen_rate = RATE_RESET;
	logic [15:0] gen_bits = BITS_RESET;
	logic [15:0] gen_ch = CHANNELS_RESET;

	// parser model state and its copy of the registers
	logic [31:0] want_rate = RATE_RESET;
	logic [15:0] want_bits = BITS_RESET;
	logic [15:0] want_ch = CHANNELS_RESET;
	phase_t pr_phase = PH_RIFF;
	logic [1:0] pr_idx = 2'd0;
	logic [31:0] pr_acc = 32'd0;
	logic [31:0] pr_pos = 32'd0;
	logic [31:0] pr_skip = 32'd0;
	logic [31:0] pr_byte_rate = 32'd0;
	logic [15:0] pr_align = 16'd0;
	logic pr_done = 1'b0;

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	function automatic int field_bytes(input phase_t p);
		case (p)
		PH_AUDIO_FMT, PH_CHANNELS, PH_BLOCK_ALIGN, PH_BITS: field_bytes = 2;
		PH_SKIPPING: field_bytes = 1;
		default: field_bytes = 4;
		endcase
	endfunction

	task automatic clear_parse();
		pr_phase = PH_RIFF;
		pr_idx = 2'd0;
		pr_acc = 32'd0;
		pr_pos = 32'd0;
		pr_skip = 32'd0;
		pr_byte_rate = 32'd0;
		pr_align = 16'd0;
		pr_done = 1'b0;
	endtask

	task automatic log_result(input status_t st, input logic [31:0] off, input logic [30:0] cnt);
		result_t r;
		r.status = st;
		r.data_offset = off;
		r.sample_count = cnt;
		r.byte_rate_out = pr_byte_rate;
		r.block_align_out = pr_align;
		due_results.push_back(r);
		pr_done = 1'b1;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic first);
		logic [31:0] v;
		if (first)
			clear_parse();
		if (pr_done)
			return;
		if (pr_pos != 32'hFFFF_FFFF)
			pr_pos = pr_pos + 32'd1;
		if (pr_phase == PH_SKIPPING) begin
			pr_skip = pr_skip - 32'd1;
			if (pr_skip == 32'd0)
				pr_phase = PH_DATA_ID;
			return;
		end
		pr_acc = pr_acc | ({24'd0, b} << (8 * pr_idx));
		pr_idx = pr_idx + 2'd1;
		if (pr_idx != 2'd0 && pr_idx < field_bytes(pr_phase))
			return;
		v = pr_acc;
		pr_acc = 32'd0;
		pr_idx = 2'd0;
		case (pr_phase)
		PH_RIFF: begin
			if (v != TAG_RIFF) begin
				log_result(ST_NO_RIFF, 32'd0, 31'd0);
				return;
			end
		end
		PH_WAVE: begin
			if (v != TAG_WAVE) begin
				log_result(ST_NO_WAVE, 32'd0, 31'd0);
				return;
			end
		end
		PH_FMT: begin
			if (v != TAG_FMT) begin
				log_result(ST_NO_FMT, 32'd0, 31'd0);
				return;
			end
		end
		PH_AUDIO_FMT: begin
			if (v != {16'd0, FMT_PCM}) begin
				log_result(ST_COMPRESSED, 32'd0, 31'd0);
				return;
			end
		end
		PH_CHANNELS: begin
			if (v != {16'd0, want_ch}) begin
				log_result(ST_CHANNELS, 32'd0, 31'd0);
				return;
			end
		end
		PH_RATE: begin
			if (v != want_rate) begin
				log_result(ST_RATE, 32'd0, 31'd0);
				return;
			end
		end
		PH_BYTE_RATE: pr_byte_rate = v;
		PH_BLOCK_ALIGN: pr_align = v[15:0];
		PH_BITS: begin
			if (v != {16'd0, want_bits}) begin
				log_result(ST_BITS, 32'd0, 31'd0);
				return;
			end
		end
		PH_CHUNK_ID: begin
			if (v == TAG_FACT || v == TAG_LIST)
				pr_phase = PH_SKIP_SIZE;
			else if (v != TAG_DATA)
				log_result(ST_NO_DATA, 32'd0, 31'd0);
			else
				pr_phase = PH_DATA_SIZE;
			return;
		end
		PH_SKIP_SIZE: begin
			pr_skip = v;
			pr_phase = (v == 32'd0) ? PH_DATA_ID : PH_SKIPPING;
			return;
		end
		PH_DATA_ID: begin
			if (v != TAG_DATA)
				log_result(ST_NO_DATA, 32'd0, 31'd0);
			else
				pr_phase = PH_DATA_SIZE;
			return;
		end
		PH_DATA_SIZE: begin
			log_result(ST_OK, pr_pos, v[31:1]);
			return;
		end
		default: ;
		endcase
		pr_phase = phase_t'(pr_phase << 1);
	endtask

	// monitor: register writes, accepted bytes and returned results
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_RATE: want_rate = cfg_data;
				CFG_BITS: want_bits = cfg_data[15:0];
				CFG_CHANNELS: want_ch = cfg_data[15:0];
				default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tuser);
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[$bits(result_t)-1:0]);
				n_results++;
				if (due_results.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected result: status %0d offset %0d count %0d",
							got.status, got.data_offset, got.sample_count);
				end else begin
					want = due_results.pop_front();
					if (got.status !== want.status || got.data_offset !== want.data_offset ||
						got.sample_count !== want.sample_count ||
						got.byte_rate_out !== want.byte_rate_out ||
						got.block_align_out !== want.block_align_out) begin
						n_errors++;
						if (n_errors <= 10)
							$display("result %0d: exp st %0d off %0d cnt %0d rate %0d align %0d, got st %0d off %0d cnt %0d rate %0d align %0d",
								n_results, want.status, want.data_offset, want.sample_count,
								want.byte_rate_out, want.block_align_out, got.status,
								got.data_offset, got.sample_count, got.byte_rate_out,
								got.block_align_out);
					end
				end
			end
		end
	end

	always @(posedge clk)
		s_took <= s_tvalid && s_tready;

	// byte driver
	always @(negedge clk) begin
		logic go;
		wav_byte_t item;
		if (arst_n && (!s_tvalid || s_took)) begin
			go = byte_q.size() != 0 && (steady || $urandom_range(0, 99) >= 29);
			if (go) begin
				item = byte_q.pop_front();
				s_tdata <= item.b;
				s_tuser <= item.first;
			end
			s_tvalid <= go;
		end
	end

	// result receiver, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || $urandom_range(0, 99) >= 29;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] spoil(input logic [31:0] v, input int nbytes, input logic hit);
		spoil = hit ? v ^ (32'd1 << $urandom_range(0, 8 * nbytes - 1)) : v;
	endfunction

	task automatic put16(input logic [31:0] v);
		file_q.push_back(v[7:0]);
		file_q.push_back(v[15:8]);
	endtask

	task automatic put32(input logic [31:0] v);
		put16(v);
		put16(v >> 16);
	endtask

	task automatic make_file(input status_t fault, input int opt, input logic [31:0] opt_size,
		input int body, input int tail);
		logic [31:0] data_size;
		file_q.delete();
		put32(spoil(TAG_RIFF, 4, fault == ST_NO_RIFF));
		put32($urandom());
		put32(spoil(TAG_WAVE, 4, fault == ST_NO_WAVE));
		put32(spoil(TAG_FMT, 4, fault == ST_NO_FMT));
		put32($urandom());
		put16(spoil({16'd0, FMT_PCM}, 2, fault == ST_COMPRESSED));
		put16(spoil({16'd0, gen_ch}, 2, fault == ST_CHANNELS));
		put32(spoil(gen_rate, 4, fault == ST_RATE));
		put32($urandom());
		put16($urandom());
		put16(spoil({16'd0, gen_bits}, 2, fault == ST_BITS));
		if (opt != 0) begin
			put32((opt == 1) ? TAG_FACT : TAG_LIST);
			put32(opt_size);
			repeat (body)
				file_q.push_back(8'($urandom_range(0, 255)));
		end
		put32(spoil(TAG_DATA, 4, fault == ST_NO_DATA));
		case ($urandom_range(0, 3))
		0: data_size = 32'd0;
		1: data_size = 32'hFFFF_FFFF;
		default: data_size = $urandom();
		endcase
		put32(data_size);
		repeat (tail)
			file_q.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic queue_file(input int keep, input logic flag);
		for (int i = 0; i < keep; i++)
			byte_q.push_back('{b: file_q[i], first: (i == 0) && flag});
		n_pushed += keep;
	endtask

	task automatic queue_fill(input logic [7:0] b);
		for (int i = 0; i < 4; i++)
			byte_q.push_back('{b: b, first: i == 0});
		n_pushed += 4;
	endtask

	task automatic random_file();
		int pick;
		int size;
		int keep;
		status_t fault;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 12)) begin
				byte_q.push_back('{b: 8'($urandom_range(0, 255)), first: 1'($urandom_range(0, 1))});
				n_pushed++;
			end
			return;
		end
		fault = (pick < 55) ? ST_OK : status_t'(4'($urandom_range(1, 8)));
		size = $urandom_range(0, 9);
		make_file(fault, $urandom_range(0, 2), size, size, $urandom_range(0, 4));
		keep = file_q.size();
		if ($urandom_range(0, 9) == 0)
			keep = $urandom_range(1, keep - 1);
		queue_file(keep, $urandom_range(0, 19) != 0);
	endtask

	task automatic settle();
		while (byte_q.size() != 0 || s_tvalid || due_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input int n_items);
		int start;
		start = n_pushed;
		while (n_pushed - start < n_items)
			random_file();
		settle();
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_expected(input logic [31:0] rate, input logic [15:0] bits,
		input logic [15:0] ch);
		write_reg(CFG_RATE, rate);
		write_reg(CFG_BITS, {16'd0, bits});
		write_reg(CFG_CHANNELS, {16'd0, ch});
		gen_rate = rate;
		gen_bits = bits;
		gen_ch = ch;
		n_settings++;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: spare register, first file without restart, all-ones and all-zero tags
		write_reg(CFG_SPARE, $urandom());
		make_file(ST_OK, 1, 32'd0, 0, 3);
		queue_file(file_q.size(), 1'b0);
		queue_fill(8'hFF);
		queue_fill(8'h00);
		make_file(ST_OK, 2, 32'd3, 3, 0);
		queue_file(file_q.size(), 1'b1);
		// huge skip, cut short by the next restart
		make_file(ST_OK, 1, 32'hFFFF_FFF0, 20, 0);
		queue_file(file_q.size(), 1'b1);
		for (int st = ST_NO_WAVE; st <= ST_NO_DATA; st++) begin
			make_file(status_t'(4'(st)), 0, 32'd0, 0, 0);
			queue_file(file_q.size(), 1'b1);
		end
		make_file(ST_NO_DATA, 2, 32'd2, 2, 1);
		queue_file(file_q.size(), 1'b1);
		settle();

		// random files with a long receiver hold-off at the start
		hold_go = ~hold_go;
		random_phase(150);

		set_expected(32'd0, 16'd0, 16'd0);
		random_phase(120);

		set_expected(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		random_phase(120);

		steady = 1'b1;
		set_expected(32'd48000, 16'd24, 16'd2);
		random_phase(120);
		steady = 1'b0;

		set_expected($urandom(), 16'($urandom()), 16'($urandom()));
		random_phase(150);

		repeat (PIPE_CYCLES) @(posedge clk);
		$display("checked %0d results from %0d header bytes over %0d register settings,",
			n_results, n_pushed, n_settings);
		$display("with a receiver hold-off, a stretch without gaps and %0d mismatches", n_errors);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
